>>> rtl/midpoint_insert_lru_budget_cache_top_macros.svh
// assertion macros for the cache block
`ifndef MIDPOINT_INSERT_LRU_BUDGET_CACHE_TOP_MACROS_SVH
`define MIDPOINT_INSERT_LRU_BUDGET_CACHE_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define MLC_ASSERT_IMP(label, clk, rst_n, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
`define MLC_ASSERT_NXT(label, clk, rst_n, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`else
`define MLC_ASSERT_IMP(label, clk, rst_n, a, c, msg)
`define MLC_ASSERT_NXT(label, clk, rst_n, a, c, msg)
`endif
`endif

>>> rtl/mlc_pkg.sv
package mlc_pkg;
  localparam int KeyW  = 33;
  localparam int SizeW = 29;
  localparam int TotW  = 34;
  localparam logic [31:0] BudgetRst = 32'd16777216;

  typedef enum logic [1:0] {
    KIND_EVICT   = 2'd0,
    KIND_HIT     = 2'd1,
    KIND_MISS    = 2'd2,
    KIND_REFRESH = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    FMT_RGBA = 2'd0,
    FMT_RGB  = 2'd1,
    FMT_ETC  = 2'd2
  } fmt_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SRCH, ST_SHIFT_RD, ST_SHIFT_WR, ST_PUT,
    ST_EVICT_RD, ST_EVICT_EM, ST_FINAL, ST_OUT
  } state_t;
endpackage

>>> rtl/mlc_ram.sv
module mlc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

>>> rtl/mlc_size.sv
module mlc_size (
  input  logic        clk,
  input  logic        en,
  input  logic [1:0]  fmt,
  input  logic [13:0] w,
  input  logic [13:0] h,
  output logic [mlc_pkg::SizeW-1:0] size_r
);
  logic [13:0] cw, ch;
  logic [27:0] p;
  logic [mlc_pkg::SizeW-1:0] size_nxt;

  always_comb begin
    cw = (w > 14'd8192) ? 14'd8192 : w;
    ch = (h > 14'd8192) ? 14'd8192 : h;
    p  = cw * ch;
    case (fmt)
      mlc_pkg::FMT_RGBA: size_nxt = {1'b0, p} << 2;
      mlc_pkg::FMT_RGB:  size_nxt = {1'b0, p} + {p[27:0], 1'b0};
      mlc_pkg::FMT_ETC:  size_nxt = {2'b0, p[27:1]};
      default:           size_nxt = '0;
    endcase
  end

  // p*4 fits 29 bits since p <= 2^26
  always_ff @(posedge clk) begin
    if (en) size_r <= size_nxt;
  end
endmodule

>>> rtl/midpoint_insert_lru_budget_cache_top.sv
// one request at a time: the key list sits in a one-port-read ram and is
// scanned one slot a cycle, then moved one slot at a time, each move a read
// state then a write state; a request emits one word per eviction and a
// final word, each held until out_ready is seen.
`include "midpoint_insert_lru_budget_cache_top_macros.svh"
module midpoint_insert_lru_budget_cache_top #(
  parameter int ENTRIES = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_resource_key,
  input  logic        in_source_kind,
  input  logic        in_refresh,
  input  logic [1:0]  in_pixel_format,
  input  logic [13:0] in_tex_width,
  input  logic [13:0] in_tex_height,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_result_kind,
  output logic [31:0] out_entry_key,
  output logic        out_entry_source,
  output logic [5:0]  out_position,
  output logic        out_resident,
  output logic [32:0] out_bytes_used,
  output logic        out_last
);
  localparam int AW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);
  localparam logic [CW-1:0] FULL = CW'(ENTRIES);
  localparam int TW = mlc_pkg::TotW;
  localparam int KW = mlc_pkg::KeyW;
  localparam int SW = mlc_pkg::SizeW;

  mlc_pkg::state_t st_r, st_nxt, ret_r, ret_nxt;
  logic [31:0] budget_r;
  logic [CW-1:0] cnt_r, cnt_nxt, i_r, i_nxt, j_r, j_nxt;
  logic [TW-1:0] tot_r, tot_nxt;
  logic [KW-1:0] key_r;
  logic refresh_r, hit_r, hit_nxt;
  logic [SW-1:0] sz;
  logic [SW-1:0] hsz_r, hsz_nxt;

  logic k_we, s_we;
  logic [AW-1:0] waddr, raddr;
  logic [KW-1:0] kw, krd;
  logic [SW-1:0] sw, srd;

  logic [1:0] o_kind_r, o_kind_nxt;
  logic [KW-1:0] o_key_r, o_key_nxt;
  logic [5:0] o_pos_r, o_pos_nxt;
  logic o_res_r, o_res_nxt, o_last_r, o_last_nxt;
  logic [TW-1:0] o_tot_r, o_tot_nxt;
  logic rd_ok_r, rd_ok_nxt;

  mlc_size u_size (.clk(clk), .en(in_valid && in_ready), .fmt(in_pixel_format),
                   .w(in_tex_width), .h(in_tex_height), .size_r(sz));
  mlc_ram #(.WIDTH(KW), .DEPTH(ENTRIES)) u_keys (.clk(clk), .we(k_we),
    .waddr(waddr), .wdata(kw), .raddr(raddr), .rdata(krd));
  mlc_ram #(.WIDTH(SW), .DEPTH(ENTRIES)) u_sizes (.clk(clk), .we(s_we),
    .waddr(waddr), .wdata(sw), .raddr(raddr), .rdata(srd));

  assign in_ready = (st_r == mlc_pkg::ST_IDLE);
  assign out_valid = (st_r == mlc_pkg::ST_OUT);
  assign out_result_kind = o_kind_r;
  assign out_entry_key = o_key_r[31:0];
  assign out_entry_source = o_key_r[32];
  assign out_position = o_pos_r;
  assign out_resident = o_res_r;
  assign out_bytes_used = o_tot_r[TW-1] ? {33{1'b1}} : o_tot_r[32:0];
  assign out_last = o_last_r;

  // read address follows the scan index
  always_comb begin
    raddr = i_nxt[AW-1:0] - AW'(1);
  end

  always_comb begin
    st_nxt = st_r; ret_nxt = ret_r; cnt_nxt = cnt_r; i_nxt = i_r; j_nxt = j_r;
    tot_nxt = tot_r; hit_nxt = hit_r; hsz_nxt = hsz_r;
    rd_ok_nxt = 1'b0;
    k_we = 1'b0; s_we = 1'b0; waddr = i_r[AW-1:0]; kw = krd; sw = srd;
    o_kind_nxt = o_kind_r; o_key_nxt = o_key_r; o_pos_nxt = o_pos_r;
    o_res_nxt = o_res_r; o_last_nxt = o_last_r; o_tot_nxt = o_tot_r;
    case (st_r)
      mlc_pkg::ST_IDLE: begin
        if (in_valid) begin
          st_nxt = mlc_pkg::ST_SRCH; i_nxt = '0; hit_nxt = 1'b0;
        end
      end
      mlc_pkg::ST_SRCH: begin
        // rd_ok_r marks that krd holds slot i_r-1
        if (rd_ok_r && krd == key_r) begin
          hit_nxt = 1'b1; hsz_nxt = srd; j_nxt = '0;
          i_nxt = i_r - CW'(1);
          st_nxt = (i_r == CW'(1)) ? mlc_pkg::ST_PUT : mlc_pkg::ST_SHIFT_RD;
        end else if (i_r >= cnt_r) begin
          if (cnt_r == FULL) begin
            i_nxt = cnt_r; ret_nxt = mlc_pkg::ST_SHIFT_RD;
            st_nxt = mlc_pkg::ST_EVICT_RD;
          end else begin
            j_nxt = cnt_r >> 1; i_nxt = cnt_r;
            st_nxt = (cnt_r == j_nxt) ? mlc_pkg::ST_PUT : mlc_pkg::ST_SHIFT_RD;
          end
        end else begin
          i_nxt = i_r + CW'(1); rd_ok_nxt = 1'b1;
        end
      end
      mlc_pkg::ST_SHIFT_RD: begin
        if (ret_r == mlc_pkg::ST_SHIFT_RD && !hit_r && j_r != (cnt_r >> 1)) begin
          j_nxt = cnt_r >> 1; i_nxt = cnt_r;
        end
        st_nxt = mlc_pkg::ST_SHIFT_WR;
        if (!hit_r && i_r == (cnt_r >> 1) && cnt_r != FULL) st_nxt = mlc_pkg::ST_PUT;
      end
      mlc_pkg::ST_SHIFT_WR: begin
        // slot i gets slot i-1
        k_we = 1'b1; s_we = 1'b1;
        i_nxt = i_r - CW'(1);
        st_nxt = (i_nxt == j_r) ? mlc_pkg::ST_PUT : mlc_pkg::ST_SHIFT_RD;
      end
      mlc_pkg::ST_PUT: begin
        k_we = 1'b1; s_we = 1'b1; waddr = j_r[AW-1:0]; kw = key_r;
        o_key_nxt = key_r; o_last_nxt = 1'b1; ret_nxt = mlc_pkg::ST_IDLE;
        if (hit_r) begin
          sw = refresh_r ? sz : hsz_r;
          tot_nxt = refresh_r ? tot_r - TW'(hsz_r) + TW'(sz) : tot_r;
          o_kind_nxt = refresh_r ? mlc_pkg::KIND_REFRESH : mlc_pkg::KIND_HIT;
          o_pos_nxt = '0; o_res_nxt = 1'b1; o_tot_nxt = tot_nxt;
          st_nxt = mlc_pkg::ST_OUT;
        end else begin
          sw = sz; tot_nxt = tot_r + TW'(sz); cnt_nxt = cnt_r + CW'(1);
          st_nxt = mlc_pkg::ST_FINAL;
        end
      end
      mlc_pkg::ST_FINAL: begin
        if (tot_r > TW'(budget_r) && cnt_r != '0) begin
          i_nxt = cnt_r; ret_nxt = mlc_pkg::ST_FINAL;
          st_nxt = mlc_pkg::ST_EVICT_RD;
        end else begin
          o_kind_nxt = mlc_pkg::KIND_MISS; o_key_nxt = key_r; o_last_nxt = 1'b1;
          o_res_nxt = (j_r < cnt_r);
          o_pos_nxt = (j_r < cnt_r) ? 6'(j_r) : 6'd0;
          o_tot_nxt = tot_r; ret_nxt = mlc_pkg::ST_IDLE;
          st_nxt = mlc_pkg::ST_OUT;
        end
      end
      mlc_pkg::ST_EVICT_RD: st_nxt = mlc_pkg::ST_EVICT_EM;
      mlc_pkg::ST_EVICT_EM: begin
        cnt_nxt = cnt_r - CW'(1); tot_nxt = tot_r - TW'(srd);
        o_kind_nxt = mlc_pkg::KIND_EVICT; o_key_nxt = krd;
        o_pos_nxt = 6'(cnt_nxt); o_res_nxt = 1'b0; o_last_nxt = 1'b0;
        o_tot_nxt = tot_nxt; st_nxt = mlc_pkg::ST_OUT;
        if (ret_r == mlc_pkg::ST_SHIFT_RD) begin
          j_nxt = cnt_nxt >> 1; i_nxt = cnt_nxt;
          ret_nxt = mlc_pkg::ST_PUT;
        end
      end
      mlc_pkg::ST_OUT: begin
        if (out_ready) begin
          if (o_last_r) st_nxt = mlc_pkg::ST_IDLE;
          else if (ret_r == mlc_pkg::ST_PUT) begin
            st_nxt = (i_r == j_r) ? mlc_pkg::ST_PUT : mlc_pkg::ST_SHIFT_RD;
          end else st_nxt = mlc_pkg::ST_FINAL;
        end
      end
      default: st_nxt = mlc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= mlc_pkg::ST_IDLE; ret_r <= mlc_pkg::ST_IDLE;
      cnt_r <= '0; tot_r <= '0; budget_r <= mlc_pkg::BudgetRst;
      rd_ok_r <= 1'b0; hit_r <= 1'b0;
    end else begin
      st_r <= st_nxt; ret_r <= ret_nxt; cnt_r <= cnt_nxt; tot_r <= tot_nxt;
      rd_ok_r <= rd_ok_nxt; hit_r <= hit_nxt;
      if (cfg_we) budget_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    i_r <= i_nxt; j_r <= j_nxt; hsz_r <= hsz_nxt;
    o_kind_r <= o_kind_nxt; o_key_r <= o_key_nxt; o_pos_r <= o_pos_nxt;
    o_res_r <= o_res_nxt; o_last_r <= o_last_nxt; o_tot_r <= o_tot_nxt;
    if (in_valid && in_ready) begin
      key_r <= {in_source_kind, in_resource_key};
      refresh_r <= in_refresh;
    end
  end

  `MLC_ASSERT_IMP(a_cnt_max, clk, rst_n, 1'b1, cnt_r <= FULL, "entry count above depth")
  `MLC_ASSERT_IMP(a_busy, clk, rst_n, out_valid, !in_ready, "input taken while word pending")
  `MLC_ASSERT_NXT(a_hold, clk, rst_n, out_valid && !out_ready,
                  out_valid && $stable(o_key_r), "output word dropped")
endmodule

>>> bench/mlc_cache_checker.sv
module mlc_cache_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [31:0] in_resource_key,
  input  logic        in_source_kind,
  input  logic        in_refresh,
  input  logic [1:0]  in_pixel_format,
  input  logic [13:0] in_tex_width,
  input  logic [13:0] in_tex_height,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  out_result_kind,
  input  logic [31:0] out_entry_key,
  input  logic        out_entry_source,
  input  logic [5:0]  out_position,
  input  logic        out_resident,
  input  logic [32:0] out_bytes_used,
  input  logic        out_last,
  output int          fails,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Slots = 32;
  localparam logic [13:0] DimMax = 14'd8192;

  typedef struct {
    mlc_pkg::kind_t kind;
    logic [32:0]    key;
    logic [5:0]     pos;
    logic           resident;
    logic [32:0]    used;
    logic           last;
  } cache_word_t;

  logic [mlc_pkg::KeyW-1:0]  lru_key[Slots];
  logic [mlc_pkg::SizeW-1:0] lru_size[Slots];
  int unsigned               lru_count;
  logic [mlc_pkg::TotW-1:0]  lru_total;
  logic [31:0]               budget;
  cache_word_t               word_q[$];

  function automatic logic [mlc_pkg::SizeW-1:0] texture_bytes(logic [1:0] fmt,
                                                              logic [13:0] w,
                                                              logic [13:0] h);
    logic [31:0] cw, ch, px;
    cw = (w > DimMax) ? DimMax : w;
    ch = (h > DimMax) ? DimMax : h;
    px = cw * ch;
    case (fmt)
      mlc_pkg::FMT_RGBA: return mlc_pkg::SizeW'(px * 4);
      mlc_pkg::FMT_RGB:  return mlc_pkg::SizeW'(px * 3);
      mlc_pkg::FMT_ETC:  return mlc_pkg::SizeW'(px >> 1);
      default:           return '0;
    endcase
  endfunction

  task automatic push_word(mlc_pkg::kind_t kind, logic [32:0] key, int unsigned pos,
                           logic res, logic last);
    cache_word_t w;
    w.kind = kind;
    w.key = key;
    w.pos = pos[5:0];
    w.resident = res;
    // saturate when every slot holds the largest texture
    w.used = (lru_total > 34'h1FFFFFFFF) ? 33'h1FFFFFFFF : lru_total[32:0];
    w.last = last;
    word_q.push_back(w);
  endtask

  task automatic drop_tail();
    if (lru_count != 0) begin
      lru_count--;
      lru_total = lru_total - lru_size[lru_count];
      push_word(mlc_pkg::KIND_EVICT, lru_key[lru_count], lru_count, 1'b0, 1'b0);
    end
  endtask

  task automatic lookup_and_update(logic [32:0] key, logic refresh,
                                   logic [mlc_pkg::SizeW-1:0] sz);
    logic [mlc_pkg::SizeW-1:0] s;
    int unsigned mid;
    for (int i = 0; i < lru_count; i++) begin
      if (lru_key[i] == key) begin
        s = lru_size[i];
        for (int j = i; j > 0; j--) begin
          lru_key[j] = lru_key[j-1];
          lru_size[j] = lru_size[j-1];
        end
        lru_key[0] = key;
        if (refresh) begin
          lru_total = lru_total - s + sz;
          s = sz;
        end
        lru_size[0] = s;
        push_word(refresh ? mlc_pkg::KIND_REFRESH : mlc_pkg::KIND_HIT, key, 0, 1'b1, 1'b1);
        return;
      end
    end
    if (lru_count >= Slots) drop_tail();
    mid = lru_count / 2;
    for (int i = lru_count; i > mid; i--) begin
      lru_key[i] = lru_key[i-1];
      lru_size[i] = lru_size[i-1];
    end
    lru_key[mid] = key;
    lru_size[mid] = sz;
    lru_count++;
    lru_total = lru_total + sz;
    while (lru_total > {2'b00, budget} && lru_count > 0) drop_tail();
    if (mid < lru_count) push_word(mlc_pkg::KIND_MISS, key, mid, 1'b1, 1'b1);
    else push_word(mlc_pkg::KIND_MISS, key, 0, 1'b0, 1'b1);
  endtask

  always @(posedge clk) begin
    cache_word_t e;
    if (!rst_n) begin
      lru_count = 0;
      lru_total = '0;
      budget = mlc_pkg::BudgetRst;
      word_q.delete();
      fails <= 0;
      pending <= 0;
    end else begin
      if (cfg_we) budget = cfg_wdata;
      if (in_valid && in_ready)
        lookup_and_update({in_source_kind, in_resource_key}, in_refresh,
                          texture_bytes(in_pixel_format, in_tex_width, in_tex_height));
      if (out_valid && out_ready) begin
        if (word_q.size() == 0) begin
          if (fails < 10)
            $display("unexpected word: kind %0d key %h", out_result_kind, out_entry_key);
          fails <= fails + 1;
        end else begin
          e = word_q.pop_front();
          if (e.kind != out_result_kind || e.key != {out_entry_source, out_entry_key} ||
              e.pos != out_position || e.resident != out_resident ||
              e.used != out_bytes_used || e.last != out_last) begin
            if (fails < 10)
              $display("word mismatch: exp kind %0d key %h pos %0d res %0b used %0d last %0b",
                       e.kind, e.key, e.pos, e.resident, e.used, e.last,
                       " / got kind %0d key %h pos %0d res %0b used %0d last %0b",
                       out_result_kind, {out_entry_source, out_entry_key}, out_position,
                       out_resident, out_bytes_used, out_last);
            fails <= fails + 1;
          end
        end
      end
      pending <= word_q.size();
    end
  end
endmodule

>>> bench/tb_midpoint_insert_lru_budget_cache_top.sv
module tb_midpoint_insert_lru_budget_cache_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] FmtNone = 2'd3;
  localparam int StallLimit = 6000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] in_resource_key = '0;
  logic        in_source_kind = 1'b0;
  logic        in_refresh = 1'b0;
  logic [1:0]  in_pixel_format = '0;
  logic [13:0] in_tex_width = '0;
  logic [13:0] in_tex_height = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_result_kind;
  logic [31:0] out_entry_key;
  logic        out_entry_source;
  logic [5:0]  out_position;
  logic        out_resident;
  logic [32:0] out_bytes_used;
  logic        out_last;
  int          fails;
  int          pending;
  bit          steady;
  int          words_taken;
  int          quiet_cycles;

  always #4 clk = ~clk;

  midpoint_insert_lru_budget_cache_top u_dut (.*);

  mlc_cache_checker u_chk (.*);

  // no idling on either side while steady is set
  task automatic send_request(logic [31:0] key, logic src, logic refresh, logic [1:0] fmt,
                              logic [13:0] w, logic [13:0] h);
    int gap;
    in_valid <= 1'b1;
    in_resource_key <= key;
    in_source_kind <= src;
    in_refresh <= refresh;
    in_pixel_format <= fmt;
    in_tex_width <= w;
    in_tex_height <= h;
    @(posedge clk);
    while (!(in_valid && in_ready)) @(posedge clk);
    gap = steady ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_budget(logic [31:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_request();
    logic [31:0] key;
    logic [13:0] w, h;
    key = ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, 47);
    if ($urandom_range(0, 19) == 0) begin
      w = 14'($urandom_range(0, 16383));
      h = 14'($urandom_range(0, 16383));
    end else begin
      w = 14'($urandom_range(0, 80));
      h = 14'($urandom_range(0, 80));
    end
    send_request(key, 1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0,
                 2'($urandom_range(0, 3)), w, h);
  endtask

  // receiver: random stall per word, plus one long hold-off to back up the block
  initial begin
    int stall;
    bit held;
    held = 0;
    words_taken = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 14);
      if (!held && words_taken >= 150) begin
        held = 1;
        stall = 500;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!(out_valid && out_ready)) @(posedge clk);
      words_taken++;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("midpoint_insert_lru_budget_cache_top regression: fail");
      $finish;
    end
  end

  initial begin
    logic [31:0] budgets[5];
    budgets = '{32'd20000, 32'hFFFFFFFF, mlc_pkg::BudgetRst, 32'd300000, 32'd1};
    steady = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_budget(mlc_pkg::BudgetRst);
    send_request(32'd0, 1'b0, 1'b0, mlc_pkg::FMT_RGBA, 14'd1, 14'd1);
    send_request(32'd0, 1'b1, 1'b0, mlc_pkg::FMT_RGB, 14'd2, 14'd5);
    send_request(32'd0, 1'b0, 1'b0, mlc_pkg::FMT_RGB, 14'd9, 14'd9);
    send_request(32'd0, 1'b0, 1'b1, mlc_pkg::FMT_ETC, 14'd3, 14'd3);
    send_request(32'hFFFFFFFF, 1'b1, 1'b1, mlc_pkg::FMT_ETC, 14'd8192, 14'd8192);
    send_request(32'd7, 1'b0, 1'b0, FmtNone, 14'd100, 14'd100);
    send_request(32'd8, 1'b1, 1'b0, mlc_pkg::FMT_RGBA, 14'd0, 14'd16383);
    send_request(32'd9, 1'b0, 1'b0, mlc_pkg::FMT_RGBA, 14'd16383, 14'd16383);
    send_request(32'hFFFFFFFF, 1'b1, 1'b1, mlc_pkg::FMT_RGBA, 14'd4096, 14'd4096);
    send_request(32'h5555AAAA, 1'b0, 1'b0, mlc_pkg::FMT_RGB, 14'd10, 14'd10);
    send_request(32'h5555AAAA, 1'b0, 1'b0, mlc_pkg::FMT_RGB, 14'd1, 14'd1);

    // zero budget: only empty textures survive
    write_budget(32'd0);
    send_request(32'd11, 1'b0, 1'b0, mlc_pkg::FMT_RGBA, 14'd2, 14'd2);
    send_request(32'd12, 1'b1, 1'b0, FmtNone, 14'd16383, 14'd1);
    send_request(32'd13, 1'b0, 1'b1, mlc_pkg::FMT_ETC, 14'd1, 14'd1);
    for (int i = 0; i < 32; i++)
      send_request(32'd1000 + i, 1'b0, 1'b0, FmtNone, 14'd1, 14'd1);
    for (int r = 0; r < 3; r++)
      for (int i = 0; i < 32; i++)
        send_request(32'd1000 + i, 1'b0, 1'b0, FmtNone, 14'd1, 14'd1);

    // refresh every slot to the largest texture so the total saturates
    write_budget(32'hFFFFFFFF);
    steady = 1;
    for (int i = 0; i < 32; i++)
      send_request(32'd1000 + i, 1'b0, 1'b1, mlc_pkg::FMT_RGBA, 14'd16383, 14'd16383);
    steady = 0;

    for (int p = 0; p < 5; p++) begin
      write_budget(budgets[p]);
      steady = (p == 2);
      for (int n = 0; n < 42; n++) random_request();
      steady = 0;
    end

    drain();
    repeat (200) @(posedge clk);
    if (fails == 0 && pending == 0)
      $display("midpoint_insert_lru_budget_cache_top regression: pass");
    else
      $display("midpoint_insert_lru_budget_cache_top regression: fail");
    $finish;
  end
endmodule
